// ===== rtl/cbre_pkg.sv =====
// ----------------------------------------------------------------------------
// cbre_pkg - shared types and constants of the cubic Bezier ring evaluator
// Holds the ring geometry, item codes, register indexes, controller states
// and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package cbre_pkg;

   localparam int RING_SLOTS = 4;
   localparam int SLOT_W     = 2;
   localparam int NUM_AXES   = 3;
   localparam int T_W        = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int MAC_CNT_W  = 3;

   // 1.0 in Q1.16
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   // Item codes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_Z = 2'd2;

   // Last step of the multiply-accumulate walk: one extra step drains the
   // product register into the accumulator.
   localparam logic [MAC_CNT_W-1:0] MAC_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_WGT,
      ST_MAC,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic                write_pt;   // store the item's point in its slot
      logic                load_eval;  // latch t and start slot
      logic                calc_prod;  // form t^2, u^2, 3tu
      logic                calc_wgt;   // form and round the four weights
      logic                mac_mul;    // multiply point by weight
      logic                mac_clr;    // clear accumulators
      logic                mac_acc;    // add product into accumulators
      logic [SLOT_W-1:0]   mac_k;      // ring offset of this step
      logic                finish;     // round, add seed, clip, present
   } dp_cmd_type;

endpackage

// ===== rtl/cubic_bezier_ring_eval.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_ring_eval - cubic Bezier evaluator over a ring of 3-D points
// Top level: joins the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage
//   Request beat: raise start with req_* fields; the beat is taken at a rising
//   edge where start is high and busy is low. req_mode selects the item:
//     write    - store req_coord_x/y/z in ring slot req_slot; busy stays low
//                and no result beat follows.
//     evaluate - weight the four points from req_slot onward (wrapping at four)
//                by the cubic Bernstein weights of req_curve_t (Q1.16, clamped
//                at 1.0), add the seed vector, clip to the coordinate range.
//   Result beat: rsp_valid is high for exactly one cycle with rsp_out_x/y/z
//   and rsp_saturated. The receiver cannot stall; the beat is simply taken.
//   Busy rises after the request edge and falls as the result beat shows, so
//   evaluations do not overlap. The busy window covers, in order, the t/u
//   products, the weight products, the per-axis multiply-accumulate lanes
//   (four points plus drain) and rounding, seed add and clip.
//   Configuration: csr_we with csr_index writes seed_x/y/z; other indexes are
//   ignored. Write seeds only while the block is idle.
//   Reset (synchronous, active high) clears the ring and seeds to zero and
//   returns the controller to idle; the block is ready the next cycle.
// ----------------------------------------------------------------------------
module cubic_bezier_ring_eval
   import cbre_pkg::*;
#(
   parameter int COORD_WIDTH = 32
)
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [SLOT_W-1:0]             req_slot,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic [T_W-1:0]                req_curve_t,
   // result channel
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_saturated,
   // configuration port
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata
);

   dp_cmd_type cmd;

   // Sequencer: owns busy and steps the datapath
   cbre_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Datapath: ring, seeds, weights, MAC lanes and output register
   cbre_dpath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_slot      (req_slot),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_curve_t   (req_curve_t),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== rtl/cbre_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbre_ctrl - sequencing controller
// Accepts items, steps the datapath through weight generation, the
// multiply-accumulate walk over the ring and the final rounding.
// ----------------------------------------------------------------------------
module cbre_ctrl
   import cbre_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_mode,
   output logic       busy,
   output dp_cmd_type cmd
);

   ctrl_state_type        state_ff, state_in;
   logic [MAC_CNT_W-1:0]  k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.mac_k = k_ff[SLOT_W-1:0];
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            k_in = '0;
            if (start) begin
               if (req_mode == MODE_WRITE) begin
                  cmd.write_pt = 1'b1;
               end else begin
                  cmd.load_eval = 1'b1;
                  state_in      = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in      = ST_WGT;
         end
         ST_WGT: begin
            cmd.calc_wgt = 1'b1;
            state_in     = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_mul = (k_ff != MAC_LAST);
            cmd.mac_clr = (k_ff == '0);
            cmd.mac_acc = (k_ff != '0);
            k_in        = k_ff + 1'b1;
            if (k_ff == MAC_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/cbre_dpath.sv =====
// ----------------------------------------------------------------------------
// cbre_dpath - arithmetic datapath
// Control point ring, seed registers, Bernstein weight generation,
// three multiply-accumulate lanes and the round, seed-add and clip stage.
// ----------------------------------------------------------------------------
module cbre_dpath
   import cbre_pkg::*;
#(
   parameter int COORD_WIDTH = 32
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   input  logic [SLOT_W-1:0]             req_slot,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic [T_W-1:0]                req_curve_t,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_saturated
);

   localparam int CW  = COORD_WIDTH;
   localparam int WF  = 61 - CW;          // weight fraction bits
   localparam int WW  = WF + 1;           // weight width, holds 1.0
   localparam int SH  = 48 - WF;          // weight rounding shift
   localparam int MW  = 2 * T_W + 2 + T_W; // raw weight product width
   localparam int PW  = CW + WW + 1;      // point times weight
   localparam int AW  = CW + WF + 3;      // accumulator
   localparam int RW  = AW - WF;          // rounded sum
   localparam int SW  = RW + 1;           // rounded sum plus seed

   localparam logic [MW-1:0] W_HALF = MW'(1) << (47 - WF);
   localparam logic signed [AW-1:0] A_HALF = AW'(1) << (WF - 1);
   localparam logic signed [SW-1:0] MAX_V = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] MIN_V = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Ring and seeds
   logic signed [CW-1:0] pt_ff [RING_SLOTS][NUM_AXES];
   logic signed [CW-1:0] seed_ff [NUM_AXES];

   // Weight generation
   logic [SLOT_W-1:0]    slot_ff;
   logic [T_W-1:0]       t_ff, u_ff;
   logic [T_W+1:0]       t3_ff;
   logic [2*T_W-1:0]     t2_ff, u2_ff;
   logic [2*T_W+1:0]     tu3_ff;
   logic [WW-1:0]        w_ff [RING_SLOTS];

   logic [T_W-1:0]       t_sat, u_sat;
   logic [MW-1:0]        wm [RING_SLOTS];
   logic [MW-1:0]        wr [RING_SLOTS];

   // MAC lanes
   logic [SLOT_W-1:0]    rd_idx;
   logic signed [WW:0]   w_sel;
   logic signed [PW-1:0] prod [NUM_AXES];
   logic signed [PW-1:0] p_ff [NUM_AXES];
   logic signed [AW-1:0] acc_ff [NUM_AXES];

   // Finish stage
   logic signed [AW-1:0] shifted [NUM_AXES];
   logic signed [SW-1:0] total [NUM_AXES];
   logic signed [CW-1:0] clip [NUM_AXES];
   logic [NUM_AXES-1:0]  clipped;

   logic signed [CW-1:0] out_ff [NUM_AXES];
   logic                 sat_ff;
   logic                 valid_ff;

   // Clamp t above one
   assign t_sat = req_curve_t[T_W-1] ? T_ONE : req_curve_t;
   assign u_sat = T_ONE - t_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < RING_SLOTS; s++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
               pt_ff[s][c] <= '0;
            end
         end
         for (int c = 0; c < NUM_AXES; c++) begin
            seed_ff[c] <= '0;
         end
      end else begin
         if (cmd.write_pt) begin
            pt_ff[req_slot][0] <= req_coord_x;
            pt_ff[req_slot][1] <= req_coord_y;
            pt_ff[req_slot][2] <= req_coord_z;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEED_X: seed_ff[0] <= csr_wdata;
               CSR_SEED_Y: seed_ff[1] <= csr_wdata;
               CSR_SEED_Z: seed_ff[2] <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Weight products: u^3, 3tu*u, 3tu*t, t^3
   always_comb begin
      wm[0] = MW'(u2_ff * u_ff);
      wm[1] = MW'(tu3_ff * u_ff);
      wm[2] = MW'(tu3_ff * t_ff);
      wm[3] = MW'(t2_ff * t_ff);
      for (int i = 0; i < RING_SLOTS; i++) begin
         wr[i] = (wm[i] + W_HALF) >> SH;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_eval) begin
         slot_ff <= req_slot;
         t_ff    <= t_sat;
         u_ff    <= u_sat;
         t3_ff   <= {2'b00, t_sat} + {1'b0, t_sat, 1'b0};
      end
      if (cmd.calc_prod) begin
         t2_ff  <= (2*T_W)'(t_ff * t_ff);
         u2_ff  <= (2*T_W)'(u_ff * u_ff);
         tu3_ff <= (2*T_W+2)'(t3_ff * u_ff);
      end
      if (cmd.calc_wgt) begin
         for (int i = 0; i < RING_SLOTS; i++) begin
            w_ff[i] <= wr[i][WW-1:0];
         end
      end
   end

   // Walk the ring from the start slot, wrapping at four
   assign rd_idx = slot_ff + cmd.mac_k;
   assign w_sel  = $signed({1'b0, w_ff[cmd.mac_k]});

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         prod[c] = PW'(pt_ff[rd_idx][c] * w_sel);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_AXES; c++) begin
         if (cmd.mac_mul) begin
            p_ff[c] <= prod[c];
         end
         if (cmd.mac_clr) begin
            acc_ff[c] <= '0;
         end else if (cmd.mac_acc) begin
            acc_ff[c] <= acc_ff[c] + {{(AW-PW){p_ff[c][PW-1]}}, p_ff[c]};
         end
      end
   end

   // Round half up, add seed, clip
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         shifted[c] = (acc_ff[c] + A_HALF) >>> WF;
         total[c]   = {shifted[c][RW-1], shifted[c][RW-1:0]}
                    + {{(SW-CW){seed_ff[c][CW-1]}}, seed_ff[c]};
         clipped[c] = 1'b0;
         if (total[c] > MAX_V) begin
            clip[c]    = MAX_V[CW-1:0];
            clipped[c] = 1'b1;
         end else if (total[c] < MIN_V) begin
            clip[c]    = MIN_V[CW-1:0];
            clipped[c] = 1'b1;
         end else begin
            clip[c] = total[c][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            out_ff[c] <= clip[c];
         end
         sat_ff <= |clipped;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ===== rtl/cbre_chk.sv =====
// ----------------------------------------------------------------------------
// cbre_chk - port-level checks of the Bezier ring evaluator
// Watches the request and result beats and the busy window between them.
// ----------------------------------------------------------------------------
module cbre_chk
   import cbre_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_valid
);

   // An evaluation beat opens the busy window
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_EVAL) |=> busy)
      else $error("evaluation did not raise busy");

   // A write beat completes at once
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_WRITE) |=> !busy)
      else $error("write raised busy");

   // The result beat comes exactly as the busy window closes
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   // One beat per evaluation
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

endmodule

bind cubic_bezier_ring_eval cbre_chk u_cbre_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid)
);
